// ----- rtl/core/tpa_pkg.sv -----
// Shared types, codes and defaults of the tuner preemption allocator.
// Used by the channel interfaces, the allocator core and its sequencer.
`default_nettype none

package tpa_pkg;

	localparam int MAX_CLIENTS_DEF = 16;
	localparam int ID_BITS_DEF = 8;

	localparam int CFG_W = 5;
	localparam int CFG_IDX_W = 1;
	localparam int PORT_ID_W = 8;
	localparam int STATUS_W = 3;

	localparam logic CMD_ATTACH = 1'b0;
	localparam logic CMD_DETACH = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_TUNER_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_AUDIO_SRC_COUNT = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
	localparam logic [STATUS_W-1:0] ST_DUP = 3'd1;
	localparam logic [STATUS_W-1:0] ST_OPEN_FAIL = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL = 3'd4;

	typedef struct packed {
		logic                 cmd;
		logic [PORT_ID_W-1:0] client_id;
		logic                 want_audio;
		logic                 open_ok;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic                 lost_valid;
		logic [PORT_ID_W-1:0] lost_id;
		logic                 gained_valid;
		logic [PORT_ID_W-1:0] gained_id;
		logic                 audio_off;
		logic                 audio_on;
	} rsp_t;

	typedef struct packed {
		logic [CFG_W-1:0] tuner_count;
		logic [CFG_W-1:0] audio_source_count;
	} cfg_t;

endpackage

`default_nettype wire

// ----- rtl/core/tpa_if.sv -----
// Valid/ready channel interfaces for request and response items.
// Depends on tpa_pkg for the payload types.
`default_nettype none

interface tpa_req_if;
	import tpa_pkg::*;
	logic valid;
	logic ready;
	req_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface tpa_rsp_if;
	import tpa_pkg::*;
	logic valid;
	logic ready;
	rsp_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/tuner_preemption_allocator_core.sv -----
// Tuner preemption allocator: request/response channels of attach and detach
// items, a table of up to MAX_CLIENTS clients kept in one RAM in age order.
//
// req carries one item (cmd, client_id, want_audio, open_ok); rsp returns
// exactly one result item for it (status, lost and gained client, audio
// disconnect and connect). The two configuration registers are written
// through cfg_we/cfg_idx/cfg_wdata; the user must write them only while the
// block is idle, which the block itself does not enforce.
//
// Items are handled one at a time. An attach takes a scan of the table, one
// entry per cycle through the RAM read port, then up to two writes. A detach
// scans the table, then shifts the younger entries down one per cycle and may
// write one grant.
//
// Reset empties the table (the entry count goes to zero; no clearing pass) and
// sets both tuner counts to one. The result sits in an output register, so a
// new item is taken while rsp is stalled; a second finished result waits in
// the sequencer until the output register frees.
`default_nettype none

module tuner_preemption_allocator_core #(
	parameter int MAX_CLIENTS = tpa_pkg::MAX_CLIENTS_DEF,
	parameter int ID_BITS = tpa_pkg::ID_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [tpa_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  wire logic [tpa_pkg::CFG_W-1:0]        cfg_wdata,
	tpa_req_if.sink                               req,
	tpa_rsp_if.source                             rsp
);

	import tpa_pkg::*;

	localparam int AW = $clog2(MAX_CLIENTS);
	localparam int EW = ID_BITS + 2;

	cfg_t          cfg_q;
	logic          rsp_valid_q;
	rsp_t          rsp_q;

	logic          res_valid, res_ready;
	rsp_t          res_data;
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [EW-1:0] ram_wdata, ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tuner_count <= CFG_W'(1);
			cfg_q.audio_source_count <= CFG_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_TUNER_COUNT: cfg_q.tuner_count <= cfg_wdata;
				CFG_AUDIO_SRC_COUNT: cfg_q.audio_source_count <= cfg_wdata;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	assign res_ready = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			rsp_q <= '0;
		end else if (res_ready) begin
			rsp_valid_q <= res_valid;
			if (res_valid) begin
				rsp_q <= res_data;
			end
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.payload = rsp_q;

	tpa_seq #(
		.MAX_CLIENTS (MAX_CLIENTS),
		.ID_BITS     (ID_BITS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.req_data  (req.payload),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	tpa_ram #(
		.WIDTH (EW),
		.DEPTH (MAX_CLIENTS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

`default_nettype wire

// ----- rtl/core/tpa_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module tpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/core/tpa_seq.sv -----
// Sequencer of the allocator: scans the client table in RAM, decides
// preemption or reallocation, and writes the table back. Depends on tpa_pkg.
`default_nettype none

module tpa_seq #(
	parameter int MAX_CLIENTS = tpa_pkg::MAX_CLIENTS_DEF,
	parameter int ID_BITS = tpa_pkg::ID_BITS_DEF,
	localparam int AW = $clog2(MAX_CLIENTS),
	localparam int EW = ID_BITS + 2
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire tpa_pkg::cfg_t cfg,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire tpa_pkg::req_t req_data,
	output logic               res_valid,
	input  wire logic          res_ready,
	output tpa_pkg::rsp_t      res_data,
	output logic               ram_we,
	output logic [AW-1:0]      ram_waddr,
	output logic [EW-1:0]      ram_wdata,
	output logic [AW-1:0]      ram_raddr,
	input  wire logic [EW-1:0] ram_rdata
);

	import tpa_pkg::*;

	localparam int CW = $clog2(MAX_CLIENTS + 1);
	localparam int CMPW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_DECIDE, S_VICTIM_WR, S_NEW_WR, S_SHIFT, S_GRANT_WR, S_DONE
	} state_t;

	state_t state_q;

	logic               cmd_q, audio_q, ok_q;
	logic [ID_BITS-1:0] id_q;
	logic [CW-1:0]      count_q, rd_addr_q;
	logic               v_s1;
	logic [AW-1:0]      idx_s1;

	logic               found_q, held_q, aoff_q, grant_q;
	logic [AW-1:0]      found_idx_q;
	logic [CW-1:0]      n_audio_q, n_plain_q;
	// Oldest holders (attach) and youngest waiting clients (detach).
	logic               oa_v_q, op_v_q, ya_v_q, yp_v_q;
	logic [AW-1:0]      oa_idx_q, op_idx_q, ya_idx_q, yp_idx_q;
	logic [ID_BITS-1:0] oa_id_q, op_id_q, ya_id_q, yp_id_q;

	logic [AW-1:0]      sel_idx_q;
	logic [ID_BITS-1:0] sel_id_q;
	logic               sel_audio_q;
	rsp_t               res_q;

	logic [ID_BITS-1:0] e_id;
	logic               e_audio, e_tuner, hit, cnt_en;
	logic [AW-1:0]      new_idx;
	logic               lim_audio, lim_tuner, audio_free;
	logic               vic_v, vic_audio;
	logic [AW-1:0]      vic_idx;
	logic [ID_BITS-1:0] vic_id;
	logic               pick_v, pick_audio;
	logic [AW-1:0]      pick_idx;
	logic [ID_BITS-1:0] pick_id;
	logic               pass_end;

	assign e_id = ram_rdata[EW-1:2];
	assign e_audio = ram_rdata[1];
	assign e_tuner = ram_rdata[0];
	assign hit = v_s1 && (e_id == id_q) && !found_q;
	// On detach the removed entry is left out, and later entries move down by one.
	assign cnt_en = v_s1 && ((cmd_q == CMD_ATTACH) || !hit);
	assign new_idx = found_q ? (idx_s1 - AW'(1)) : idx_s1;
	assign pass_end = (rd_addr_q == count_q) && !v_s1;

	assign lim_audio = CMPW'(n_audio_q) >= CMPW'(cfg.audio_source_count);
	assign lim_tuner = (CMPW'(n_audio_q) + CMPW'(n_plain_q)) >= CMPW'(cfg.tuner_count);
	assign audio_free = !lim_audio;

	always_comb begin
		vic_v = 1'b0;
		vic_audio = 1'b1;
		vic_idx = oa_idx_q;
		vic_id = oa_id_q;
		if (audio_q) begin
			vic_v = lim_audio && oa_v_q;
		end else if (lim_tuner) begin
			if (op_v_q) begin
				vic_v = 1'b1;
				vic_audio = 1'b0;
				vic_idx = op_idx_q;
				vic_id = op_id_q;
			end else begin
				vic_v = oa_v_q;
			end
		end
	end

	always_comb begin
		pick_v = yp_v_q;
		pick_audio = 1'b0;
		pick_idx = yp_idx_q;
		pick_id = yp_id_q;
		if (audio_free && ya_v_q) begin
			pick_v = 1'b1;
			pick_audio = 1'b1;
			pick_idx = ya_idx_q;
			pick_id = ya_id_q;
		end
	end

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = sel_idx_q;
		ram_wdata = {sel_id_q, sel_audio_q, 1'b0};
		case (state_q)
			S_VICTIM_WR: ram_we = 1'b1;
			S_GRANT_WR: begin
				ram_we = 1'b1;
				ram_wdata = {sel_id_q, sel_audio_q, 1'b1};
			end
			S_NEW_WR: begin
				ram_we = 1'b1;
				ram_waddr = count_q[AW-1:0];
				ram_wdata = {id_q, audio_q, 1'b1};
			end
			S_SHIFT: begin
				ram_we = v_s1;
				ram_waddr = idx_s1 - AW'(1);
				ram_wdata = ram_rdata;
			end
			default: ram_we = 1'b0;
		endcase
	end

	assign ram_raddr = rd_addr_q[AW-1:0];
	assign req_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res_data = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd_q <= CMD_ATTACH;
			audio_q <= 1'b0;
			ok_q <= 1'b0;
			id_q <= '0;
			count_q <= '0;
			rd_addr_q <= '0;
			v_s1 <= 1'b0;
			idx_s1 <= '0;
			found_q <= 1'b0;
			held_q <= 1'b0;
			aoff_q <= 1'b0;
			grant_q <= 1'b0;
			found_idx_q <= '0;
			n_audio_q <= '0;
			n_plain_q <= '0;
			oa_v_q <= 1'b0;
			op_v_q <= 1'b0;
			ya_v_q <= 1'b0;
			yp_v_q <= 1'b0;
			oa_idx_q <= '0;
			op_idx_q <= '0;
			ya_idx_q <= '0;
			yp_idx_q <= '0;
			oa_id_q <= '0;
			op_id_q <= '0;
			ya_id_q <= '0;
			yp_id_q <= '0;
			sel_idx_q <= '0;
			sel_id_q <= '0;
			sel_audio_q <= 1'b0;
			res_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						cmd_q <= req_data.cmd;
						id_q <= ID_BITS'(req_data.client_id);
						audio_q <= req_data.want_audio;
						ok_q <= req_data.open_ok;
						rd_addr_q <= '0;
						v_s1 <= 1'b0;
						found_q <= 1'b0;
						n_audio_q <= '0;
						n_plain_q <= '0;
						oa_v_q <= 1'b0;
						op_v_q <= 1'b0;
						ya_v_q <= 1'b0;
						yp_v_q <= 1'b0;
						// The result is built up field by field from a cleared register.
						res_q <= '0;
						grant_q <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (rd_addr_q < count_q) begin
						v_s1 <= 1'b1;
						idx_s1 <= rd_addr_q[AW-1:0];
						rd_addr_q <= rd_addr_q + CW'(1);
					end else begin
						v_s1 <= 1'b0;
					end
					if (hit) begin
						found_q <= 1'b1;
						found_idx_q <= idx_s1;
						held_q <= e_tuner;
						aoff_q <= e_audio;
					end
					if (cnt_en) begin
						if (e_tuner) begin
							if (e_audio) begin
								n_audio_q <= n_audio_q + CW'(1);
								if (!oa_v_q) begin
									oa_v_q <= 1'b1;
									oa_idx_q <= idx_s1;
									oa_id_q <= e_id;
								end
							end else begin
								n_plain_q <= n_plain_q + CW'(1);
								if (!op_v_q) begin
									op_v_q <= 1'b1;
									op_idx_q <= idx_s1;
									op_id_q <= e_id;
								end
							end
						end else if (e_audio) begin
							ya_v_q <= 1'b1;
							ya_idx_q <= new_idx;
							ya_id_q <= e_id;
						end else begin
							yp_v_q <= 1'b1;
							yp_idx_q <= new_idx;
							yp_id_q <= e_id;
						end
					end
					if (pass_end) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (cmd_q == CMD_ATTACH) begin
						if (found_q) begin
							res_q.status <= ST_DUP;
							state_q <= S_DONE;
						end else if (count_q == CW'(MAX_CLIENTS)) begin
							res_q.status <= ST_FULL;
							state_q <= S_DONE;
						end else begin
							sel_idx_q <= vic_idx;
							sel_id_q <= vic_id;
							sel_audio_q <= vic_audio;
							if (vic_v) begin
								res_q.lost_valid <= 1'b1;
								res_q.lost_id <= PORT_ID_W'(vic_id);
								res_q.audio_off <= vic_audio;
								state_q <= S_VICTIM_WR;
							end else if (ok_q) begin
								state_q <= S_NEW_WR;
							end else begin
								res_q.status <= ST_OPEN_FAIL;
								state_q <= S_DONE;
							end
						end
					end else if (!found_q) begin
						res_q.status <= ST_NOT_FOUND;
						state_q <= S_DONE;
					end else begin
						rd_addr_q <= CW'(found_idx_q) + CW'(1);
						v_s1 <= 1'b0;
						sel_idx_q <= pick_idx;
						sel_id_q <= pick_id;
						sel_audio_q <= pick_audio;
						if (held_q) begin
							res_q.audio_off <= aoff_q;
							if (pick_v) begin
								if (ok_q) begin
									grant_q <= 1'b1;
									res_q.gained_valid <= 1'b1;
									res_q.gained_id <= PORT_ID_W'(pick_id);
									res_q.audio_on <= pick_audio;
								end else begin
									res_q.status <= ST_OPEN_FAIL;
								end
							end
						end
						state_q <= S_SHIFT;
					end
				end
				S_VICTIM_WR: begin
					if (ok_q) begin
						state_q <= S_NEW_WR;
					end else begin
						res_q.status <= ST_OPEN_FAIL;
						state_q <= S_DONE;
					end
				end
				S_NEW_WR: begin
					count_q <= count_q + CW'(1);
					res_q.gained_valid <= 1'b1;
					res_q.gained_id <= PORT_ID_W'(id_q);
					res_q.audio_on <= audio_q;
					state_q <= S_DONE;
				end
				S_SHIFT: begin
					// Each entry read here is written one place lower next cycle.
					if (rd_addr_q < count_q) begin
						v_s1 <= 1'b1;
						idx_s1 <= rd_addr_q[AW-1:0];
						rd_addr_q <= rd_addr_q + CW'(1);
					end else begin
						v_s1 <= 1'b0;
					end
					if (pass_end) begin
						count_q <= count_q - CW'(1);
						state_q <= grant_q ? S_GRANT_WR : S_DONE;
					end
				end
				S_GRANT_WR: state_q <= S_DONE;
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_CLIENTS))
		else $error("client count beyond table depth");

	a_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (state_q == S_SCAN))
		else $error("accepted item did not start a table scan");

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q != S_IDLE && state_q != S_SCAN && state_q != S_DONE))
		else $error("table written outside an update step");

	a_dup_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_data.status == ST_DUP)
		|-> (!res_data.lost_valid && !res_data.gained_valid))
		else $error("duplicate attach changed tuner ownership");
`endif

endmodule

`default_nettype wire
